[rtl/core/tdh_pkg.sv]
// Shared types, codes and helpers for the timer deadline queue.
// Used by tdh_cell and timer_deadline_heap; no dependencies.
package tdh_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 64;
  localparam int unsigned ID_W    = 6;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned S_DATA_W = 72;
  localparam int unsigned M_DATA_W = 80;

  localparam logic [TIME_W-1:0] FOREVER = '1;

  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   tid;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_POP    = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   key;
  } cell_ctl_t;

  // order by deadline, ties to the lower timer id
  function automatic logic key_less(input entry_t a, input entry_t b);
    key_less = {a.deadline, a.tid} < {b.deadline, b.tid};
  endfunction

endpackage

[rtl/core/timer_deadline_heap.sv]
// Top level of the timer deadline queue: command sequencer, sorted cell chain,
// deadline RAM and the result register. Depends on tdh_pkg, tdh_cell, tdh_ram.
//
// A pool of NUM_TIMERS one-shot timers kept in deadline order in a chain of
// cells, earliest first (ties go to the lower timer id). Every command word
// on the s_ side gives one or more result words on the m_ side; tlast marks
// the final one. Each chain update (remove, insert or pop) acts on all cells
// at once. A start passes through the remove, insert and ack states, a
// cancel through remove and ack, an unused code or an out-of-range id
// straight to ack, and a tick through the pop state, which emits one word
// per expired timer or goes on to ack when nothing expires; a new command
// is taken once the previous one has put its last word into the output
// register. A word waiting at the output stalls the sequencer only when it
// has another word to emit. No clearing pass is needed after reset.
module timer_deadline_heap #(
  parameter int unsigned NUM_TIMERS = tdh_pkg::NUM_TIMERS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // cmd[1:0], timer_id[7:2], delay[39:8], now_time[71:40]
  input  logic [tdh_pkg::S_DATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // expired_id[5:0], elapsed[37:6], next_deadline[69:38], none_pending[70],
  // pending_count[77:71], zero[79:78]
  output logic [tdh_pkg::M_DATA_W-1:0] m_tdata,
  // kind[0]
  output logic                         m_tuser,
  output logic                         m_tlast
);

  localparam int unsigned IW = $clog2(NUM_TIMERS);
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REMOVE = 5'b00010,
    ST_INSERT = 5'b00100,
    ST_POP    = 5'b01000,
    ST_ACK    = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [tdh_pkg::CMD_W-1:0]  cmd_q;
  logic [tdh_pkg::ID_W-1:0]   id_q;
  logic [tdh_pkg::TIME_W-1:0] delay_q;
  logic [tdh_pkg::TIME_W-1:0] cur_time;
  logic [CW-1:0]              count;
  logic [NUM_TIMERS-1:0]      armed;

  logic [tdh_pkg::CMD_W-1:0]  in_cmd;
  logic [tdh_pkg::ID_W-1:0]   in_id;
  logic                       accept;
  logic                       in_range;
  logic                       id_q_range;
  logic [IW-1:0]              idx_q;

  // result register
  logic                       kind_r;
  logic [tdh_pkg::ID_W-1:0]   exp_id_r;
  logic [tdh_pkg::TIME_W-1:0] elapsed_r;
  logic [tdh_pkg::TIME_W-1:0] next_dl_r;
  logic                       none_r;
  logic [tdh_pkg::CNT_W-1:0]  count_r;
  logic                       last_r;
  logic                       out_free;

  // chain
  tdh_pkg::cell_ctl_t         ctl;
  logic [NUM_TIMERS-1:0]      cv;
  logic [NUM_TIMERS-1:0]      cb;
  tdh_pkg::entry_t            ce [NUM_TIMERS];

  logic [tdh_pkg::TIME_W-1:0] ram_rdata;
  logic                       ram_we;
  logic [tdh_pkg::TIME_W:0]   dl_sum;
  logic [tdh_pkg::TIME_W-1:0] new_dl;
  logic                       rm_hit;
  logic                       head_pops;
  logic                       second_pops;
  logic                       pop_now;
  logic                       ack_now;

  assign in_cmd     = s_tdata[1:0];
  assign in_id      = s_tdata[7:2];
  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign in_range   = {1'b0, in_id} < 7'(NUM_TIMERS);
  assign id_q_range = {1'b0, id_q} < 7'(NUM_TIMERS);
  assign idx_q      = id_q[IW-1:0];
  assign out_free   = !m_tvalid || m_tready;

  assign dl_sum = {1'b0, cur_time} + {1'b0, delay_q};
  assign new_dl = dl_sum[tdh_pkg::TIME_W] ? tdh_pkg::FOREVER : dl_sum[tdh_pkg::TIME_W-1:0];

  assign rm_hit      = (state == ST_REMOVE) && id_q_range && armed[idx_q];
  assign head_pops   = cv[0] && (ce[0].deadline <= cur_time);
  assign second_pops = cv[1] && (ce[1].deadline <= cur_time);
  assign pop_now     = (state == ST_POP) && head_pops && out_free;
  assign ack_now     = (state == ST_ACK) && out_free;
  assign ram_we      = (state == ST_INSERT);

  tdh_ram #(
    .WIDTH (tdh_pkg::TIME_W),
    .DEPTH (NUM_TIMERS)
  ) u_dl_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_q),
    .wdata (new_dl),
    .raddr (in_id[IW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    ctl.op           = tdh_pkg::OP_HOLD;
    ctl.key.deadline = ram_rdata;
    ctl.key.tid      = id_q;
    ctl.key.stamp    = cur_time;
    if (state == ST_INSERT) begin
      ctl.op           = tdh_pkg::OP_INSERT;
      ctl.key.deadline = new_dl;
    end else if (rm_hit) begin
      ctl.op = tdh_pkg::OP_REMOVE;
    end else if (pop_now) begin
      ctl.op = tdh_pkg::OP_POP;
    end
  end

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic            lv, lb, rv;
    tdh_pkg::entry_t le, re;
    if (i == 0) begin : g_first
      assign lv = 1'b0;
      assign lb = 1'b0;
      assign le = ctl.key;
    end else begin : g_mid
      assign lv = cv[i-1];
      assign lb = cb[i-1];
      assign le = ce[i-1];
    end
    if (i == NUM_TIMERS - 1) begin : g_end
      assign rv = 1'b0;
      assign re = ctl.key;
    end else begin : g_inner
      assign rv = cv[i+1];
      assign re = ce[i+1];
    end
    tdh_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_valid  (lv),
      .left_entry  (le),
      .left_before (lb),
      .right_valid (rv),
      .right_entry (re),
      .valid       (cv[i]),
      .entry       (ce[i]),
      .ahead       (cb[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == tdh_pkg::CMD_TICK) begin
            state_next = ST_POP;
          end else if ((in_cmd == tdh_pkg::CMD_START || in_cmd == tdh_pkg::CMD_CANCEL)
                       && in_range) begin
            state_next = ST_REMOVE;
          end else begin
            state_next = ST_ACK;
          end
        end
      end
      ST_REMOVE: begin
        state_next = (cmd_q == tdh_pkg::CMD_START) ? ST_INSERT : ST_ACK;
      end
      ST_INSERT: begin
        state_next = ST_ACK;
      end
      ST_POP: begin
        // only reached with nothing popped yet when the head is not due
        if (!head_pops) begin
          state_next = ST_ACK;
        end else if (pop_now && !second_pops) begin
          state_next = ST_IDLE;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur_time <= '0;
      count    <= '0;
      armed    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && in_cmd == tdh_pkg::CMD_TICK) begin
        cur_time <= s_tdata[71:40];
      end
      if (rm_hit) begin
        count        <= count - CW'(1);
        armed[idx_q] <= 1'b0;
      end else if (state == ST_INSERT) begin
        count        <= count + CW'(1);
        armed[idx_q] <= 1'b1;
      end else if (pop_now) begin
        count                    <= count - CW'(1);
        armed[ce[0].tid[IW-1:0]] <= 1'b0;
      end
      if (pop_now || ack_now) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= in_cmd;
      id_q    <= in_id;
      delay_q <= s_tdata[39:8];
    end
    if (pop_now) begin
      // fields as they stand once the head has left the chain
      kind_r    <= tdh_pkg::KIND_EXPIRY;
      exp_id_r  <= ce[0].tid;
      elapsed_r <= cur_time - ce[0].stamp;
      next_dl_r <= cv[1] ? ce[1].deadline : tdh_pkg::FOREVER;
      none_r    <= !cv[1];
      count_r   <= tdh_pkg::CNT_W'(count - CW'(1));
      last_r    <= !second_pops;
    end else if (ack_now) begin
      kind_r    <= tdh_pkg::KIND_ACK;
      exp_id_r  <= '0;
      elapsed_r <= '0;
      next_dl_r <= cv[0] ? ce[0].deadline : tdh_pkg::FOREVER;
      none_r    <= !cv[0];
      count_r   <= tdh_pkg::CNT_W'(count);
      last_r    <= 1'b1;
    end
  end

  assign m_tdata = {2'b00, count_r, none_r, next_dl_r, elapsed_r, exp_id_r};
  assign m_tuser = kind_r;
  assign m_tlast = last_r;

  a_count_matches_armed: assert property (@(posedge clk) disable iff (rst)
    32'(count) == $countones(armed))
    else $error("pending count differs from armed set");

  a_head_valid_iff_pending: assert property (@(posedge clk) disable iff (rst)
    cv[0] == (count != '0))
    else $error("chain head disagrees with pending count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    state == ST_INSERT |=> count == $past(count) + CW'(1))
    else $error("insert did not add one timer");

  a_pop_in_order: assert property (@(posedge clk) disable iff (rst)
    pop_now && cv[1] |-> !tdh_pkg::key_less(ce[1], ce[0]))
    else $error("chain out of deadline order at pop");

endmodule

[rtl/core/tdh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/tdh_cell.sv]
// One cell of the sorted timer chain: holds at most one armed timer.
// Depends on tdh_pkg; instantiated in a row by timer_deadline_heap.
module tdh_cell (
  input  logic               clk,
  input  logic               rst,
  input  tdh_pkg::cell_ctl_t ctl,
  input  logic               left_valid,
  input  tdh_pkg::entry_t    left_entry,
  input  logic               left_before,
  input  logic               right_valid,
  input  tdh_pkg::entry_t    right_entry,
  output logic               valid,
  output tdh_pkg::entry_t    entry,
  output logic               ahead
);

  logic            valid_next;
  tdh_pkg::entry_t entry_next;
  logic            at_or_after;

  // new key sorts ahead of this cell's entry (empty cells sort last)
  assign ahead       = !valid || tdh_pkg::key_less(ctl.key, entry);
  assign at_or_after = valid && !tdh_pkg::key_less(entry, ctl.key);

  always_comb begin
    valid_next = valid;
    entry_next = entry;
    unique case (ctl.op)
      tdh_pkg::OP_HOLD: begin
      end
      tdh_pkg::OP_INSERT: begin
        if (left_before) begin
          valid_next = left_valid;
          entry_next = left_entry;
        end else if (ahead) begin
          valid_next = 1'b1;
          entry_next = ctl.key;
        end
      end
      tdh_pkg::OP_REMOVE: begin
        if (at_or_after) begin
          valid_next = right_valid;
          entry_next = right_entry;
        end
      end
      tdh_pkg::OP_POP: begin
        valid_next = right_valid;
        entry_next = right_entry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
